FILE: hdl/ggc_pkg.sv
// Shared types, constants and tables for the go-to-goal controller.
// No dependencies; the other files except ggc_ifs refer to it by scoped names.
package ggc_pkg;

  localparam int CordicStepsDef = 16;
  localparam int SqrtSteps      = 17;   // one result bit per step, 34-bit radicand
  localparam int SqWidth        = 34;
  localparam int AngWidth       = 32;

  localparam logic signed [AngWidth-1:0] AngPi     = 32'sd52707179;
  localparam logic signed [AngWidth-1:0] AngHalfPi = 32'sd26353589;

  localparam logic [16:0] SpeedMax = 17'd131071;
  localparam logic signed [39:0] RateMin = -40'sd262144;
  localparam logic signed [39:0] RateMax = 40'sd262143;

  localparam logic signed [15:0] GoalXRst = 16'sd1024;
  localparam logic signed [15:0] GoalYRst = 16'sd1024;
  localparam logic [15:0]        TolRst   = 16'd102;

  typedef enum logic [1:0] {
    REG_GOAL_X = 2'd0,
    REG_GOAL_Y = 2'd1,
    REG_TOL    = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_e;

  localparam logic signed [AngWidth-1:0] AtanTab [24] = '{
    32'sd13176795, 32'sd7778716, 32'sd4110060, 32'sd2086331,
    32'sd1047214,  32'sd524117,  32'sd262123,  32'sd131069,
    32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192, 32'sd4096, 32'sd2048,
    32'sd1024, 32'sd512, 32'sd256, 32'sd128, 32'sd64, 32'sd32, 32'sd16,
    32'sd8, 32'sd4, 32'sd2
  };

  // Front stage result: squares registered before they are summed.
  typedef struct packed {
    logic [SqWidth-1:0]         ax2;
    logic [SqWidth-1:0]         ay2;
    logic [31:0]                tol2;
    logic signed [AngWidth-1:0] cx;
    logic signed [AngWidth-1:0] cy;
    logic signed [AngWidth-1:0] cz;
    logic                       spec;
    logic signed [AngWidth-1:0] sz;
    logic signed [15:0]         hd;
  } front_t;

  // Word carried through the root / CORDIC stages.
  typedef struct packed {
    logic signed [AngWidth-1:0] cx;
    logic signed [AngWidth-1:0] cy;
    logic signed [AngWidth-1:0] cz;
    logic [SqWidth:0]           sn;
    logic [SqWidth:0]           sr;
    logic                       spec;
    logic signed [AngWidth-1:0] sz;
    logic signed [15:0]         hd;
    logic                       arr;
  } pipe_t;

endpackage

FILE: hdl/ggc_ifs.sv
// Valid/ready channel interfaces for the go-to-goal controller.
// Depends on nothing but plain logic types.
interface ggc_pose_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] heading;
  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface

interface ggc_cmd_if;
  logic               valid;
  logic               ready;
  logic [16:0]        linear_speed;
  logic signed [18:0] angular_rate;
  logic               arrived;
  modport source (output valid, linear_speed, angular_rate, arrived, input ready);
  modport sink   (input valid, linear_speed, angular_rate, arrived, output ready);
endinterface

interface ggc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/go_to_goal_p_controller.sv
// Top level of the proportional go-to-goal controller.
// Depends on ggc_pkg, ggc_ifs, ggc_front, ggc_step and ggc_back.
//
// Takes one pose word per cycle unless stalled, returns one command word per pose, in
// order: linear speed = rounded Euclidean distance to the goal, angular rate
// = 4 * (atan2 bearing - heading) rounded to Q5.13 and saturated, and an
// arrival flag when distance squared <= tolerance squared. The pipeline is
// a front register (offsets and squares), a sum register, max(17,
// CORDIC_STEPS) stages that each resolve at most one root bit and one CORDIC step,
// and an output register. Throughput is one word per cycle while the
// command side is not stalled; a stall on the command side freezes the
// whole pipeline, and nothing is dropped or repeated. Configuration writes
// are always taken and apply to poses accepted after them; write only while
// the pipeline is empty.
module go_to_goal_p_controller #(
  parameter int CORDIC_STEPS = ggc_pkg::CordicStepsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ggc_cfg_if.sink  cfg_i,
  ggc_pose_if.sink pose_i,
  ggc_cmd_if.source cmd_o
);
  localparam int Depth = (CORDIC_STEPS > ggc_pkg::SqrtSteps) ?
                         CORDIC_STEPS : ggc_pkg::SqrtSteps;

  // Configuration registers.
  logic signed [15:0] goal_x_q, goal_y_q;
  logic [15:0]        tol_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q <= ggc_pkg::GoalXRst;
      goal_y_q <= ggc_pkg::GoalYRst;
      tol_q    <= ggc_pkg::TolRst;
    end else if (cfg_i.valid) begin
      unique case (ggc_pkg::reg_idx_e'(cfg_i.index))
        ggc_pkg::REG_GOAL_X: goal_x_q <= cfg_i.data;
        ggc_pkg::REG_GOAL_Y: goal_y_q <= cfg_i.data;
        ggc_pkg::REG_TOL:    tol_q    <= cfg_i.data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Global advance: move when the output slot is free or being taken.
  logic adv;
  assign adv          = !cmd_o.valid || cmd_o.ready;
  assign pose_i.ready = adv;

  // Front stage.
  ggc_pkg::front_t front_d, front_q;
  logic            front_v_q;

  ggc_front u_front (
    .goal_x_i  (goal_x_q),
    .goal_y_i  (goal_y_q),
    .tol_i     (tol_q),
    .pos_x_i   (pose_i.pos_x),
    .pos_y_i   (pose_i.pos_y),
    .heading_i (pose_i.heading),
    .front_o   (front_d)
  );

  // Sum stage: radicand and arrival compare.
  ggc_pkg::pipe_t pipe_d [Depth+1];
  ggc_pkg::pipe_t pipe_q [Depth+1];
  logic           pipe_v_q [Depth+1];
  logic [ggc_pkg::SqWidth-1:0] sq;

  always_comb begin
    sq             = front_q.ax2 + front_q.ay2;
    pipe_d[0].sn   = {1'b0, sq};
    pipe_d[0].sr   = '0;
    pipe_d[0].arr  = sq <= {2'b0, front_q.tol2};
    pipe_d[0].cx   = front_q.cx;
    pipe_d[0].cy   = front_q.cy;
    pipe_d[0].cz   = front_q.cz;
    pipe_d[0].spec = front_q.spec;
    pipe_d[0].sz   = front_q.sz;
    pipe_d[0].hd   = front_q.hd;
  end

  for (genvar k = 0; k < Depth; k++) begin : g_step
    ggc_step #(
      .StepIdx     (k),
      .CordicSteps (CORDIC_STEPS)
    ) u_step (
      .in_i  (pipe_q[k]),
      .out_o (pipe_d[k+1])
    );
  end

  // Output stage.
  logic [16:0]        speed_d, speed_q;
  logic signed [18:0] rate_d, rate_q;
  logic               arr_q, out_v_q;

  ggc_back u_back (
    .in_i    (pipe_q[Depth]),
    .speed_o (speed_d),
    .rate_o  (rate_d)
  );

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_v_q <= 1'b0;
      out_v_q   <= 1'b0;
      for (int k = 0; k <= Depth; k++) pipe_v_q[k] <= 1'b0;
    end else if (adv) begin
      front_v_q   <= pose_i.valid;
      pipe_v_q[0] <= front_v_q;
      for (int k = 1; k <= Depth; k++) pipe_v_q[k] <= pipe_v_q[k-1];
      out_v_q     <= pipe_v_q[Depth];
    end
  end

  // Payload registers; hold on stall.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      front_q <= front_d;
      for (int k = 0; k <= Depth; k++) pipe_q[k] <= pipe_d[k];
      speed_q <= speed_d;
      rate_q  <= rate_d;
      arr_q   <= pipe_q[Depth].arr;
    end
  end

  assign cmd_o.valid        = out_v_q;
  assign cmd_o.linear_speed = speed_q;
  assign cmd_o.angular_rate = rate_q;
  assign cmd_o.arrived      = arr_q;
endmodule

FILE: hdl/ggc_front.sv
// Front stage: goal offsets, squares, tolerance square, CORDIC pre-rotation.
// Depends on ggc_pkg.
module ggc_front (
  input  logic signed [15:0] goal_x_i,
  input  logic signed [15:0] goal_y_i,
  input  logic [15:0]        tol_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] heading_i,
  output ggc_pkg::front_t    front_o
);
  logic signed [16:0] dx, dy;
  logic [16:0]        ax, ay;
  logic signed [31:0] x0, y0;

  always_comb begin
    dx = {goal_x_i[15], goal_x_i} - {pos_x_i[15], pos_x_i};
    dy = {goal_y_i[15], goal_y_i} - {pos_y_i[15], pos_y_i};
    ax = dx[16] ? 17'(-dx) : 17'(dx);
    ay = dy[16] ? 17'(-dy) : 17'(dy);
    x0 = {{3{dx[16]}}, dx, 12'b0};
    y0 = {{3{dy[16]}}, dy, 12'b0};

    front_o.ax2  = 34'(ax) * 34'(ax);
    front_o.ay2  = 34'(ay) * 34'(ay);
    front_o.tol2 = 32'(tol_i) * 32'(tol_i);
    front_o.hd   = heading_i;

    // Rotate into the right half plane.
    if (dx[16]) begin
      front_o.cx = -x0;
      front_o.cy = -y0;
      front_o.cz = dy[16] ? -ggc_pkg::AngPi : ggc_pkg::AngPi;
    end else begin
      front_o.cx = x0;
      front_o.cy = y0;
      front_o.cz = '0;
    end

    // Offsets on an axis bypass the CORDIC result.
    front_o.spec = (dy == '0) || (dx == '0);
    if (dy == '0) begin
      front_o.sz = dx[16] ? ggc_pkg::AngPi : '0;
    end else begin
      front_o.sz = dy[16] ? -ggc_pkg::AngHalfPi : ggc_pkg::AngHalfPi;
    end
  end
endmodule

FILE: hdl/ggc_step.sv
// One stage: at most one square-root bit and one CORDIC vectoring step.
// Depends on ggc_pkg.
module ggc_step #(
  parameter int StepIdx     = 0,
  parameter int CordicSteps = ggc_pkg::CordicStepsDef
) (
  input  ggc_pkg::pipe_t in_i,
  output ggc_pkg::pipe_t out_o
);
  always_comb begin
    out_o = in_i;
    if (StepIdx < ggc_pkg::SqrtSteps) begin
      // Trial subtract against the current root estimate.
      logic [ggc_pkg::SqWidth:0] bitv, trial;
      bitv  = (ggc_pkg::SqWidth+1)'(1) << (2 * (ggc_pkg::SqrtSteps - 1 - StepIdx));
      trial = in_i.sr + bitv;
      if (in_i.sn >= trial) begin
        out_o.sn = in_i.sn - trial;
        out_o.sr = (in_i.sr >> 1) + bitv;
      end else begin
        out_o.sr = in_i.sr >> 1;
      end
    end
    if (StepIdx < CordicSteps && StepIdx < 24) begin
      if (in_i.cy > 0) begin
        out_o.cx = in_i.cx + (in_i.cy >>> StepIdx);
        out_o.cy = in_i.cy - (in_i.cx >>> StepIdx);
        out_o.cz = in_i.cz + ggc_pkg::AtanTab[StepIdx % 24];
      end else begin
        out_o.cx = in_i.cx - (in_i.cy >>> StepIdx);
        out_o.cy = in_i.cy + (in_i.cx >>> StepIdx);
        out_o.cz = in_i.cz - ggc_pkg::AtanTab[StepIdx % 24];
      end
    end
  end
endmodule

FILE: hdl/ggc_back.sv
// Back stage: root rounding, bearing error scaling, rounding and saturation.
// Depends on ggc_pkg.
module ggc_back (
  input  ggc_pkg::pipe_t     in_i,
  output logic [16:0]        speed_o,
  output logic signed [18:0] rate_o
);
  logic [ggc_pkg::SqWidth:0] root;
  logic signed [31:0]        bz;
  logic signed [39:0]        err, rnd;

  always_comb begin
    // Round to nearest: bump when the remainder exceeds the root.
    root    = in_i.sr + {{ggc_pkg::SqWidth{1'b0}}, (in_i.sn > in_i.sr)};
    speed_o = (root > {{(ggc_pkg::SqWidth-16){1'b0}}, ggc_pkg::SpeedMax}) ?
              ggc_pkg::SpeedMax : root[16:0];

    bz  = in_i.spec ? in_i.sz : in_i.cz;
    err = (40'(bz) - (40'(in_i.hd) <<< 11)) <<< 2;
    rnd = (err + 40'sd1024) >>> 11;
    if (rnd < ggc_pkg::RateMin) begin
      rate_o = ggc_pkg::RateMin[18:0];
    end else if (rnd > ggc_pkg::RateMax) begin
      rate_o = ggc_pkg::RateMax[18:0];
    end else begin
      rate_o = rnd[18:0];
    end
  end
endmodule

FILE: verif/tb_go_to_goal_p_controller.sv
// Testbench for the go-to-goal controller: random and directed pose words,
// a bit-exact predictor of distance, bearing error and arrival, and a checker.
// Depends on ggc_pkg, ggc_ifs and the go_to_goal_p_controller RTL.
module tb_go_to_goal_p_controller;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Steps = 16;
  localparam int LimitCycles = 400000;

  typedef struct {
    logic [16:0]        speed;
    logic signed [18:0] rate;
    logic               arrived;
  } cmd_word_t;

  // Expected command words, oldest first, plus a local copy of the registers.
  class cmd_scoreboard;
    cmd_word_t pending[$];
    int        errors;
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    logic [15:0]        tol;

    function void set_reg(ggc_pkg::reg_idx_e idx, logic [15:0] val);
      case (idx)
        ggc_pkg::REG_GOAL_X: goal_x = val;
        ggc_pkg::REG_GOAL_Y: goal_y = val;
        ggc_pkg::REG_TOL:    tol = val;
        default: ;
      endcase
    endfunction

    function longint floor_shift(longint v, int s);
      return v >>> s;
    endfunction

    function longint cordic_bearing(longint dx, longint dy);
      longint x, y, z, xs, ys;
      z = 0;
      if (dy == 0) return (dx < 0) ? longint'(ggc_pkg::AngPi) : 0;
      if (dx == 0) return (dy > 0) ? longint'(ggc_pkg::AngHalfPi)
                                   : -longint'(ggc_pkg::AngHalfPi);
      x = dx * 4096;
      y = dy * 4096;
      if (x < 0) begin
        z = (y >= 0) ? longint'(ggc_pkg::AngPi) : -longint'(ggc_pkg::AngPi);
        x = -x;
        y = -y;
      end
      for (int i = 0; i < Steps && i < 24; i++) begin
        xs = floor_shift(x, i);
        ys = floor_shift(y, i);
        if (y > 0) begin
          x += ys; y -= xs; z += longint'(ggc_pkg::AtanTab[i]);
        end else begin
          x -= ys; y += xs; z -= longint'(ggc_pkg::AtanTab[i]);
        end
      end
      return z;
    endfunction

    function longint unsigned root_nearest(longint unsigned s);
      longint unsigned r, b, n;
      r = 0; n = s; b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b; r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      if (s - r * r > r) r++;
      return r;
    endfunction

    // Note an accepted pose: compute its command word.
    function void note_pose(logic signed [15:0] px, logic signed [15:0] py,
                            logic signed [15:0] hd);
      longint dx, dy, err, rt;
      longint unsigned sq, span, t;
      cmd_word_t w;
      dx = longint'(goal_x) - longint'(px);
      dy = longint'(goal_y) - longint'(py);
      sq = dx * dx + dy * dy;
      t = tol;
      span = root_nearest(sq);
      if (span > 131071) span = 131071;
      err = 4 * (cordic_bearing(dx, dy) - longint'(hd) * 2048);
      rt = (err + 1024) >>> 11;
      if (rt < -262144) rt = -262144;
      if (rt > 262143) rt = 262143;
      w.speed = span[16:0];
      w.rate = rt[18:0];
      w.arrived = (sq <= t * t);
      pending.push_back(w);
    endfunction

    function void check_cmd(logic [16:0] sp, logic signed [18:0] rt, logic arr);
      cmd_word_t w;
      if (pending.size() == 0) begin
        $error("unexpected command word speed=%0d rate=%0d", sp, rt);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (sp !== w.speed) begin
        $error("linear_speed exp %0d got %0d", w.speed, sp); errors++;
      end
      if (rt !== w.rate) begin
        $error("angular_rate exp %0d got %0d", w.rate, rt); errors++;
      end
      if (arr !== w.arrived) begin
        $error("arrived exp %0d got %0d", w.arrived, arr); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #2 clk_i = ~clk_i;

  ggc_cfg_if  cfg_ch ();
  ggc_pose_if pose_ch ();
  ggc_cmd_if  cmd_ch ();

  go_to_goal_p_controller #(.CORDIC_STEPS(Steps)) u_dut (
    .clk_i (clk_i), .rst_ni(rst_ni), .cfg_i(cfg_ch.sink),
    .pose_i(pose_ch.sink), .cmd_o(cmd_ch.source)
  );

  cmd_scoreboard board = new();
  bit  quiet_tail;     // drop all idling near the end
  int  hold_off_len;   // request for a long receiver stall
  longint cycle_cnt;

  initial begin
    cfg_ch.valid = 1'b0; cfg_ch.index = ggc_pkg::REG_NONE; cfg_ch.data = '0;
    pose_ch.valid = 1'b0; pose_ch.pos_x = '0; pose_ch.pos_y = '0;
    pose_ch.heading = '0;
    cmd_ch.ready = 1'b0;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LimitCycles) begin
      $display("CHECK FAILED");
      $finish;
    end
  end
  initial cycle_cnt = 0;

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    int gap;
    hold_off_len = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (cmd_ch.valid && cmd_ch.ready)
        board.check_cmd(cmd_ch.linear_speed, cmd_ch.angular_rate, cmd_ch.arrived);
      if (hold_off_len > 0) begin
        gap = hold_off_len;
        hold_off_len = 0;
        cmd_ch.ready <= 1'b0;
        repeat (gap) begin
          @(posedge clk_i);
        end
        cmd_ch.ready <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 13);
        cmd_ch.ready <= 1'b0;
        repeat (gap - 1) @(posedge clk_i);
      end else begin
        cmd_ch.ready <= 1'b1;
      end
    end
  end

  // Write one register; only used while the pipeline is empty. The caller
  // drops valid after the last write of a burst.
  task automatic write_reg(ggc_pkg::reg_idx_e idx, logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    board.set_reg(idx, val);
  endtask

  // Offer one pose word and hold it until it is taken.
  task automatic send_pose(logic signed [15:0] px, logic signed [15:0] py,
                           logic signed [15:0] hd);
    int gap;
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      pose_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pose_ch.valid <= 1'b1;
    pose_ch.pos_x <= px;
    pose_ch.pos_y <= py;
    pose_ch.heading <= hd;
    do @(posedge clk_i); while (!pose_ch.ready);
    board.note_pose(px, py, hd);
  endtask

  task automatic drain();
    pose_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  // Half small offsets around the goal, half full range, some of those on a goal axis.
  task automatic send_random();
    logic signed [15:0] px, py, hd;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 5) begin
      px = board.goal_x + $signed(16'($urandom_range(0, 400)) - 16'sd200);
      py = board.goal_y + $signed(16'($urandom_range(0, 400)) - 16'sd200);
    end else begin
      px = 16'($urandom);
      py = 16'($urandom);
    end
    if (mode == 9) px = board.goal_x;
    if (mode == 8) py = board.goal_y;
    hd = ($urandom_range(0, 3) == 0) ? 16'($urandom)
         : 16'($signed($urandom_range(0, 51472)) - 25736);
    send_pose(px, py, hd);
  endtask

  initial begin
    logic signed [15:0] gx[4] = '{16'sh7FFF, -16'sd32768, 16'sd0, -16'sd3000};
    logic signed [15:0] gy[4] = '{-16'sd32768, 16'sh7FFF, 16'sd0, 16'sd2500};
    logic [15:0]        tl[4] = '{16'hFFFF, 16'd0, 16'd500, 16'd102};
    quiet_tail = 1'b0;
    board.goal_x = ggc_pkg::GoalXRst;
    board.goal_y = ggc_pkg::GoalYRst;
    board.tol = ggc_pkg::TolRst;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: at the goal, tolerance edge, axes, extremes of every field.
    send_pose(16'sd1024, 16'sd1024, 16'sd0);
    send_pose(16'sd1024 - 16'sd102, 16'sd1024, 16'sd0);
    send_pose(16'sd1024 - 16'sd103, 16'sd1024, -16'sd32768);
    send_pose(16'sd0, 16'sd1024, 16'sh7FFF);
    send_pose(16'sd2048, 16'sd1024, 16'sd0);
    send_pose(16'sd1024, 16'sd0, 16'sd100);
    send_pose(16'sd1024, 16'sd2048, -16'sd100);
    send_pose(-16'sd32768, -16'sd32768, 16'sh7FFF);
    send_pose(16'sh7FFF, 16'sh7FFF, -16'sd32768);
    send_pose(16'sh7FFF, -16'sd32768, 16'sd25736);
    send_pose(-16'sd32768, 16'sh7FFF, -16'sd25736);
    send_pose(16'sd0, 16'sd0, 16'sd0);
    send_pose(16'sd1000, 16'sd1030, 16'hAAAA);
    send_pose(16'sd1030, 16'sd1000, 16'h5555);
    // Idle pause: sender waits until every command is back.
    drain();

    // Phases with several register settings, extremes included.
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(ggc_pkg::REG_GOAL_X, gx[ph]);
      write_reg(ggc_pkg::REG_GOAL_Y, gy[ph]);
      write_reg(ggc_pkg::REG_TOL, tl[ph]);
      write_reg(ggc_pkg::REG_NONE, 16'h1234);
      cfg_ch.valid <= 1'b0;
      @(posedge clk_i);
      if (ph == 1) hold_off_len = 120;  // long stall to fill the pipe
      for (int n = 0; n < 330; n++) begin
        if (ph == 3 && n == 230) quiet_tail = 1'b1;
        send_random();
      end
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

FILE: filelist.f
hdl/ggc_pkg.sv
hdl/ggc_ifs.sv
hdl/ggc_front.sv
hdl/ggc_step.sv
hdl/ggc_back.sv
hdl/go_to_goal_p_controller.sv
verif/tb_go_to_goal_p_controller.sv
